>>> rtl/mass_window_intensity_sum_macros.svh
// assertion macros for the window sum block
`ifndef MASS_WINDOW_INTENSITY_SUM_MACROS_SVH
`define MASS_WINDOW_INTENSITY_SUM_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MWIS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MWIS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mwis_pkg.sv
// shared types and constants of the window sum block
package mwis_pkg;

  localparam int SEL_W  = 5;
  localparam int MASS_W = 32;
  localparam int INT_W  = 32;
  localparam int SUM_W  = 48;

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [MASS_W-1:0] MW_RESET  = 32'd1311;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEC,
    ST_FIRST,
    ST_LAST,
    ST_BS_ISSUE,
    ST_BS_CHECK,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [INT_W-1:0]  intensity;
  } point_t;

endpackage

>>> rtl/mwis_point_store.sv
// point memory: one write port, one registered read port
module mwis_point_store #(
  parameter int DEPTH = 20480,
  parameter int AW    = 15
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  mwis_pkg::point_t  wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output mwis_pkg::point_t  rd_data_o
);

  mwis_pkg::point_t mem_q [DEPTH];
  mwis_pkg::point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/mass_window_intensity_sum.sv
// top level of the mass window intensity sum block
//
// command channel: an item transfers at a clock edge with start high and busy low.
// clear empties every spectrum and the overflow flag; load appends one point to the
// selected spectrum, a point for a full spectrum is dropped and sets the sticky
// overflow flag. both keep busy low.
// query opens the window around target_mass_i and walks the spectra in turn, giving
// one result per spectrum for one cycle under result_valid_o, the last with
// last_of_run_o. busy stays high for the query.
// per spectrum: an empty one gives an empty result, else the count and first mass are read,
// then the last mass when the window starts above the first (the spectrum ends there when
// it starts at or above the last), then binary search steps (about log2 of the point
// count) and a fetch of the first point, then each point summed and a close; each
// step waits on the single read port of the point memory.
// each result shows the cycle after its spectrum closes, the last one in the cycle in
// which busy falls.
// configuration writes of the window width take effect at once and should only be
// made while busy is low.
// reset clears the point counts and the overflow flag and loads the default window;
// the point memory itself is not cleared. results cannot be stalled.
module mass_window_intensity_sum #(
  parameter int NUM_SPECTRA         = 20,
  parameter int POINTS_PER_SPECTRUM = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation_i,
  input  logic [mwis_pkg::SEL_W-1:0]  spectrum_select_i,
  input  logic [mwis_pkg::MASS_W-1:0] point_mass_i,
  input  logic [mwis_pkg::INT_W-1:0]  point_intensity_i,
  input  logic [mwis_pkg::MASS_W-1:0] target_mass_i,
  input  logic                        cfg_we_i,
  input  logic [mwis_pkg::MASS_W-1:0] cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [mwis_pkg::SEL_W-1:0]  spectrum_number_o,
  output logic [mwis_pkg::SUM_W-1:0]  intensity_sum_o,
  output logic                        spectrum_empty_o,
  output logic                        overflow_seen_o,
  output logic                        last_of_run_o
);

  `include "mass_window_intensity_sum_macros.svh"

  localparam int DEPTH = NUM_SPECTRA * POINTS_PER_SPECTRUM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(POINTS_PER_SPECTRUM + 1);
  localparam int IW    = $clog2(POINTS_PER_SPECTRUM);
  localparam int SW    = (NUM_SPECTRA > 1) ? $clog2(NUM_SPECTRA) : 1;
  localparam int MW    = mwis_pkg::MASS_W;
  localparam int SUMW  = mwis_pkg::SUM_W;

  localparam logic [AW-1:0] STRIDE = AW'(POINTS_PER_SPECTRUM);
  localparam logic [CW-1:0] FULL   = CW'(POINTS_PER_SPECTRUM);
  localparam logic [SW-1:0] K_LAST = SW'(NUM_SPECTRA - 1);

  mwis_pkg::state_e state_q, state_d;

  logic [MW-1:0]   mw_q;
  logic            ovf_q;
  logic [CW-1:0]   cnt_q [NUM_SPECTRA];

  logic [SW-1:0]   k_q, k_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [MW-1:0]   wstart_q, wstart_d;
  logic [MW:0]     wend_q, wend_d;
  logic [SUMW-1:0] sum_q, sum_d;

  logic            res_valid_q;
  logic [SW-1:0]   res_num_q;
  logic [SUMW-1:0] res_sum_q;
  logic            res_empty_q, res_ovf_q, res_last_q;

  logic            emit;
  logic [SUMW-1:0] emit_sum;
  logic            emit_empty;

  logic            accept;
  mwis_pkg::op_e   op;
  logic            sel_ok;
  logic [SW-1:0]   sel_idx;
  logic [CW-1:0]   ld_cnt;
  logic            ld_fire, ld_drop, clr_fire;
  logic [AW-1:0]   wr_addr;
  mwis_pkg::point_t wr_data, rd_data;

  logic            rd_en;
  logic [IW-1:0]   rd_off;
  logic [CW-1:0]   cur_cnt;
  logic [CW-1:0]   idx_nxt;
  logic [CW-1:0]   n_m1;
  logic [IW:0]     lo_p1, lo_hi;
  logic [MW-1:0]   half;
  logic [SUMW:0]   acc;

  assign busy   = (state_q != mwis_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign op     = mwis_pkg::op_e'(operation_i);

  // load and clear decode
  assign sel_ok   = {1'b0, spectrum_select_i} < (mwis_pkg::SEL_W + 1)'(NUM_SPECTRA);
  assign sel_idx  = spectrum_select_i[SW-1:0];
  assign ld_cnt   = cnt_q[sel_idx];
  assign clr_fire = accept && (op == mwis_pkg::OP_CLEAR);
  assign ld_fire  = accept && (op == mwis_pkg::OP_LOAD) && sel_ok && (ld_cnt != FULL);
  assign ld_drop  = accept && (op == mwis_pkg::OP_LOAD) && sel_ok && (ld_cnt == FULL);
  assign wr_addr  = AW'(sel_idx * POINTS_PER_SPECTRUM) + AW'(ld_cnt);
  assign wr_data  = '{mass: point_mass_i, intensity: point_intensity_i};

  mwis_point_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ld_fire),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (base_q + AW'(rd_off)),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q  <= mwis_pkg::MW_RESET;
      ovf_q <= 1'b0;
      for (int i = 0; i < NUM_SPECTRA; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mw_q <= cfg_wdata_i;
      end
      if (clr_fire) begin
        ovf_q <= 1'b0;
        for (int i = 0; i < NUM_SPECTRA; i++) begin
          cnt_q[i] <= '0;
        end
      end
      if (ld_drop) begin
        ovf_q <= 1'b1;
      end
      if (ld_fire) begin
        cnt_q[sel_idx] <= ld_cnt + 1'b1;
      end
    end
  end

  // window bounds and per-spectrum helpers
  assign half    = {1'b0, mw_q[MW-1:1]};
  assign cur_cnt = cnt_q[k_q];
  assign idx_nxt = idx_q + 1'b1;
  assign n_m1    = n_q - 1'b1;
  assign lo_p1   = {1'b0, lo_q} + 1'b1;
  assign lo_hi   = {1'b0, lo_q} + {1'b0, hi_q};
  assign acc     = {1'b0, sum_q} + (SUMW + 1)'(rd_data.intensity);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    base_d     = base_q;
    n_d        = n_q;
    idx_d      = idx_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    wstart_d   = wstart_q;
    wend_d     = wend_q;
    sum_d      = sum_q;
    rd_en      = 1'b0;
    rd_off     = '0;
    emit       = 1'b0;
    emit_sum   = '0;
    emit_empty = 1'b0;

    case (state_q)
      mwis_pkg::ST_IDLE: begin
        if (accept && (op == mwis_pkg::OP_QUERY)) begin
          wstart_d = (target_mass_i >= half) ? (target_mass_i - half) : '0;
          wend_d   = {1'b0, target_mass_i} + {1'b0, half};
          k_d      = '0;
          base_d   = '0;
          state_d  = mwis_pkg::ST_SPEC;
        end
      end
      mwis_pkg::ST_SPEC: begin
        n_d   = cur_cnt;
        sum_d = '0;
        if (cur_cnt == '0) begin
          emit       = 1'b1;
          emit_empty = 1'b1;
        end else begin
          rd_en   = 1'b1;
          state_d = mwis_pkg::ST_FIRST;
        end
      end
      mwis_pkg::ST_FIRST: begin
        if (wstart_q <= rd_data.mass) begin
          idx_d   = '0;
          state_d = mwis_pkg::ST_WALK;
        end else begin
          rd_en   = 1'b1;
          rd_off  = n_m1[IW-1:0];
          state_d = mwis_pkg::ST_LAST;
        end
      end
      mwis_pkg::ST_LAST: begin
        if (wstart_q >= rd_data.mass) begin
          emit = 1'b1;
        end else begin
          lo_d    = '0;
          hi_d    = n_m1[IW-1:0];
          state_d = mwis_pkg::ST_BS_ISSUE;
        end
      end
      mwis_pkg::ST_BS_ISSUE: begin
        rd_en = 1'b1;
        if (lo_p1 < {1'b0, hi_q}) begin
          mid_d   = lo_hi[IW:1];
          rd_off  = lo_hi[IW:1];
          state_d = mwis_pkg::ST_BS_CHECK;
        end else begin
          idx_d   = CW'(hi_q);
          rd_off  = hi_q;
          state_d = mwis_pkg::ST_WALK;
        end
      end
      mwis_pkg::ST_BS_CHECK: begin
        if (wstart_q < rd_data.mass) begin
          hi_d    = mid_q;
          state_d = mwis_pkg::ST_BS_ISSUE;
        end else if (wstart_q > rd_data.mass) begin
          lo_d    = mid_q;
          state_d = mwis_pkg::ST_BS_ISSUE;
        end else begin
          // exact hit, its data is already in hand
          idx_d   = CW'(mid_q);
          state_d = mwis_pkg::ST_WALK;
        end
      end
      mwis_pkg::ST_WALK: begin
        if ((idx_q < n_q) && ({1'b0, rd_data.mass} <= wend_q)) begin
          sum_d = acc[SUMW] ? mwis_pkg::SUM_MAX : acc[SUMW-1:0];
          idx_d = idx_nxt;
          if (idx_nxt < n_q) begin
            rd_en  = 1'b1;
            rd_off = idx_nxt[IW-1:0];
          end
        end else begin
          emit     = 1'b1;
          emit_sum = sum_q;
        end
      end
      default: begin
        state_d = mwis_pkg::ST_IDLE;
      end
    endcase

    if (emit) begin
      if (k_q == K_LAST) begin
        state_d = mwis_pkg::ST_IDLE;
      end else begin
        k_d     = k_q + 1'b1;
        base_d  = base_q + STRIDE;
        state_d = mwis_pkg::ST_SPEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwis_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    base_q   <= base_d;
    n_q      <= n_d;
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    wstart_q <= wstart_d;
    wend_q   <= wend_d;
    sum_q    <= sum_d;
    if (emit) begin
      res_num_q   <= k_q;
      res_sum_q   <= emit_sum;
      res_empty_q <= emit_empty;
      res_ovf_q   <= ovf_q;
      res_last_q  <= (k_q == K_LAST);
    end
  end

  assign result_valid_o    = res_valid_q;
  assign spectrum_number_o = mwis_pkg::SEL_W'(res_num_q);
  assign intensity_sum_o   = res_sum_q;
  assign spectrum_empty_o  = res_empty_q;
  assign overflow_seen_o   = res_ovf_q;
  assign last_of_run_o     = res_last_q;

  `MWIS_ASSERT_NEXT(a_query_busy, accept && (op == mwis_pkg::OP_QUERY), busy,
                    "query transfer did not start the run")
  `MWIS_ASSERT_NOW(a_last_ends_run, result_valid_o && last_of_run_o, !busy,
                   "run still busy after its last result")
  `MWIS_ASSERT_NOW(a_mid_run_busy, result_valid_o && !last_of_run_o, busy,
                   "run ended before its last result")
  `MWIS_ASSERT_NOW(a_empty_zero, result_valid_o && spectrum_empty_o, intensity_sum_o == '0,
                   "empty spectrum gave a non-zero sum")

endmodule
